// ----- src/tls_pkg.sv -----
`default_nettype none

package tls_pkg;

  localparam int unsigned GREEN_W = 8;
  localparam int unsigned PED_W   = 7;
  localparam int unsigned SECS_W  = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned REG_IDX_W = 3;

  localparam int unsigned YELLOW_SECONDS_DEF     = 3;
  localparam int unsigned NIGHT_NSLT_SECONDS_DEF = 4;
  localparam int unsigned NIGHT_EWLT_SECONDS_DEF = 4;

  // longest chain of zero-time phase changes within one tick is three
  localparam int unsigned ADV_STEPS = 4;

  localparam logic [REG_IDX_W-1:0] REG_DAY_NS_GREEN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DAY_EW_GREEN   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DAY_NSLT_GREEN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DAY_EWLT_GREEN = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NIGHT_NS_GREEN = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_NIGHT_EW_GREEN = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PED_NS_SECONDS = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_PED_EW_SECONDS = 3'd7;

  typedef enum logic [1:0] {
    LAMP_OFF    = 2'd0,
    LAMP_RED    = 2'd1,
    LAMP_GREEN  = 2'd2,
    LAMP_YELLOW = 2'd3
  } lamp_code_t;

  typedef enum logic [12:0] {
    PH_START  = 13'h0001,
    PH_NS_PED = 13'h0002,
    PH_NS_G   = 13'h0004,
    PH_NS_Y   = 13'h0008,
    PH_EWLT_G = 13'h0010,
    PH_EWLT_Y = 13'h0020,
    PH_EW_PED = 13'h0040,
    PH_EW_G   = 13'h0080,
    PH_EW_Y   = 13'h0100,
    PH_NSLT_G = 13'h0200,
    PH_NSLT_Y = 13'h0400,
    PH_FL_RED = 13'h0800,
    PH_FL_OFF = 13'h1000
  } phase_t;

  typedef struct packed {
    logic light_is_day;
    logic ns_ped_press;
    logic ew_ped_press;
    logic ewlt_car;
    logic nslt_car;
    logic flash_press;
  } tick_t;

  typedef struct packed {
    lamp_code_t       ns_lamp;
    lamp_code_t       nslt_lamp;
    lamp_code_t       ew_lamp;
    lamp_code_t       ewlt_lamp;
    logic             day_indicator;
    logic             ped_active;
    logic             ped_direction;
    logic [PED_W-1:0] countdown;
    logic             beep;
  } lamp_t;

  typedef struct packed {
    logic [GREEN_W-1:0] day_ns_green;
    logic [GREEN_W-1:0] day_ew_green;
    logic [GREEN_W-1:0] day_nslt_green;
    logic [GREEN_W-1:0] day_ewlt_green;
    logic [GREEN_W-1:0] night_ns_green;
    logic [GREEN_W-1:0] night_ew_green;
    logic [PED_W-1:0]   ped_ns_seconds;
    logic [PED_W-1:0]   ped_ew_seconds;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [SECS_W-1:0] secs;
    logic              ns_pend;
    logic              ew_pend;
    logic              fl_pend;
    logic              day;
  } seq_state_t;

endpackage

`default_nettype wire

// ----- src/tls_seq.sv -----
`default_nettype none

module tls_seq import tls_pkg::*; #(
  parameter int unsigned YELLOW_SECONDS     = YELLOW_SECONDS_DEF,
  parameter int unsigned NIGHT_NSLT_SECONDS = NIGHT_NSLT_SECONDS_DEF,
  parameter int unsigned NIGHT_EWLT_SECONDS = NIGHT_EWLT_SECONDS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  step,
  input  wire tick_t tick,
  input  wire cfg_t  cfg,
  output lamp_t      result
);

  localparam logic [SECS_W-1:0] YEL_S  = SECS_W'(YELLOW_SECONDS);
  localparam logic [SECS_W-1:0] NNSLT_S = SECS_W'(NIGHT_NSLT_SECONDS);
  localparam logic [SECS_W-1:0] NEWLT_S = SECS_W'(NIGHT_EWLT_SECONDS);

  seq_state_t state;
  seq_state_t state_next;

  function automatic seq_state_t go_to(seq_state_t s, phase_t p, logic [SECS_W-1:0] n);
    seq_state_t r;
    r = s;
    r.phase = p;
    r.secs = n;
    return r;
  endfunction

  function automatic seq_state_t begin_mode(seq_state_t s, cfg_t c);
    seq_state_t r;
    r = s;
    if (!r.day) begin
      r.ns_pend = 1'b0;
      r.ew_pend = 1'b0;
    end
    if (r.day && r.ns_pend) begin
      if (c.ped_ns_seconds != '0) begin
        return go_to(r, PH_NS_PED, SECS_W'(c.ped_ns_seconds));
      end
      r.ns_pend = 1'b0;
    end
    return go_to(r, PH_NS_G, r.day ? c.day_ns_green : c.night_ns_green);
  endfunction

  function automatic seq_state_t begin_ew(seq_state_t s, cfg_t c);
    seq_state_t r;
    r = s;
    if (r.day && r.ew_pend) begin
      if (c.ped_ew_seconds != '0) begin
        return go_to(r, PH_EW_PED, SECS_W'(c.ped_ew_seconds));
      end
      r.ew_pend = 1'b0;
    end
    return go_to(r, PH_EW_G, r.day ? c.day_ew_green : c.night_ew_green);
  endfunction

  function automatic seq_state_t flash_red_entry(seq_state_t s, cfg_t c);
    seq_state_t r;
    r = s;
    if (r.fl_pend) begin
      r.fl_pend = 1'b0;
      return begin_mode(r, c);
    end
    return go_to(r, PH_FL_RED, SECS_W'(1));
  endfunction

  function automatic seq_state_t advance(seq_state_t s, cfg_t c, tick_t t);
    seq_state_t r;
    r = s;
    case (s.phase)
      PH_START: begin
        r.day = t.light_is_day;
        if (r.fl_pend) begin
          r.fl_pend = 1'b0;
          r = flash_red_entry(r, c);
        end else begin
          r = begin_mode(r, c);
        end
      end
      PH_NS_PED: begin
        r.ns_pend = 1'b0;
        r = go_to(r, PH_NS_G, r.day ? c.day_ns_green : c.night_ns_green);
      end
      PH_NS_G: r = go_to(r, PH_NS_Y, YEL_S);
      PH_NS_Y: begin
        if (t.ewlt_car) begin
          r = go_to(r, PH_EWLT_G, r.day ? c.day_ewlt_green : NEWLT_S);
        end else begin
          r = begin_ew(r, c);
        end
      end
      PH_EWLT_G: r = go_to(r, PH_EWLT_Y, YEL_S);
      PH_EWLT_Y: r = begin_ew(r, c);
      PH_EW_PED: begin
        r.ew_pend = 1'b0;
        r = go_to(r, PH_EW_G, r.day ? c.day_ew_green : c.night_ew_green);
      end
      PH_EW_G: r = go_to(r, PH_EW_Y, YEL_S);
      PH_EW_Y: begin
        if (t.nslt_car) begin
          r = go_to(r, PH_NSLT_G, r.day ? c.day_nslt_green : NNSLT_S);
        end else begin
          r = go_to(r, PH_START, '0);
        end
      end
      PH_NSLT_G: r = go_to(r, PH_NSLT_Y, YEL_S);
      PH_FL_RED: r = go_to(r, PH_FL_OFF, SECS_W'(1));
      PH_FL_OFF: r = flash_red_entry(r, c);
      default: r = go_to(r, PH_START, '0);
    endcase
    return r;
  endfunction

  always_comb begin
    seq_state_t st;
    st = state;
    st.ns_pend = st.ns_pend | tick.ns_ped_press;
    st.ew_pend = st.ew_pend | tick.ew_ped_press;
    st.fl_pend = st.fl_pend | tick.flash_press;
    for (int i = 0; i < ADV_STEPS; i++) begin
      if (st.secs == '0) begin
        st = advance(st, cfg, tick);
      end
    end
    result = '0;
    result.ns_lamp = LAMP_RED;
    result.nslt_lamp = LAMP_RED;
    result.ew_lamp = LAMP_RED;
    result.ewlt_lamp = LAMP_RED;
    if (st.secs != '0) begin
      case (st.phase)
        PH_NS_PED, PH_NS_G: result.ns_lamp = LAMP_GREEN;
        PH_NS_Y: result.ns_lamp = LAMP_YELLOW;
        PH_EWLT_G: result.ewlt_lamp = LAMP_GREEN;
        PH_EWLT_Y: result.ewlt_lamp = LAMP_YELLOW;
        PH_EW_PED, PH_EW_G: result.ew_lamp = LAMP_GREEN;
        PH_EW_Y: result.ew_lamp = LAMP_YELLOW;
        PH_NSLT_G: result.nslt_lamp = LAMP_GREEN;
        PH_NSLT_Y: result.nslt_lamp = LAMP_YELLOW;
        PH_FL_OFF: begin
          result.ns_lamp = LAMP_OFF;
          result.nslt_lamp = LAMP_OFF;
          result.ew_lamp = LAMP_OFF;
          result.ewlt_lamp = LAMP_OFF;
        end
        default: ;
      endcase
      if (st.phase == PH_NS_PED || st.phase == PH_EW_PED) begin
        result.ped_active = 1'b1;
        result.beep = 1'b1;
        result.ped_direction = (st.phase == PH_EW_PED);
        result.countdown = PED_W'(st.secs - SECS_W'(1));
      end
      st.secs = st.secs - SECS_W'(1);
    end
    result.day_indicator = st.day;
    state_next = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= PH_START;
      state.secs <= '0;
      state.ns_pend <= 1'b0;
      state.ew_pend <= 1'b0;
      state.fl_pend <= 1'b0;
      state.day <= 1'b0;
    end else if (step) begin
      state <= state_next;
    end
  end

  a_start_left: assert property (@(posedge clk) disable iff (rst)
    step |=> state.phase != PH_START)
    else $error("sequencer rested in cycle start after an item");

  a_ped_day: assert property (@(posedge clk) disable iff (rst)
    step && (state_next.phase == PH_NS_PED || state_next.phase == PH_EW_PED)
      |-> state_next.day)
    else $error("pedestrian countdown in night mode");

  a_flash_pair: assert property (@(posedge clk) disable iff (rst)
    step && state.phase == PH_FL_RED && state.secs == '0
      |-> state_next.phase == PH_FL_OFF && result.ns_lamp == LAMP_OFF)
    else $error("flash red not followed by off");

endmodule

`default_nettype wire

// ----- src/traffic_light_sequencer_core.sv -----
// Four-approach traffic light sequencer.
// Input channel tick/tick_valid/tick_ready: one item per one-second tick with
// the day comparator bit, pedestrian and flash button pulses and left-turn
// car sensors. Output channel lamp/lamp_valid/lamp_ready: one item per tick
// with the four lamp codes, day indicator and pedestrian countdown.
// The item's result sits in the output register on the cycle after
// acceptance. It takes one item per cycle while the receiver keeps up; the
// next-state logic resolves every zero-length phase of a tick in a single pass.
// A new tick is taken while the previous result is being taken; when the
// receiver stalls with a result held, tick_ready drops until it is taken.
// Timing registers are written through cfg_write/cfg_index/cfg_data; the user
// must write them only while no item is in flight, the block does not enforce it.
// Reset restores the default timings, puts the sequencer at cycle start with
// night mode latched and clears all pending requests and lamp_valid.
`default_nettype none

module traffic_light_sequencer_core import tls_pkg::*; #(
  parameter int unsigned YELLOW_SECONDS     = YELLOW_SECONDS_DEF,
  parameter int unsigned NIGHT_NSLT_SECONDS = NIGHT_NSLT_SECONDS_DEF,
  parameter int unsigned NIGHT_EWLT_SECONDS = NIGHT_EWLT_SECONDS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 tick_valid,
  output logic                      tick_ready,
  input  wire tick_t                tick,
  output logic                      lamp_valid,
  input  wire logic                 lamp_ready,
  output lamp_t                     lamp,
  input  wire logic                 cfg_write,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  cfg_t  cfg;
  lamp_t result;
  logic  step;

  assign tick_ready = !lamp_valid || lamp_ready;
  assign step = tick_valid && tick_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.day_ns_green <= GREEN_W'(8);
      cfg.day_ew_green <= GREEN_W'(7);
      cfg.day_nslt_green <= GREEN_W'(5);
      cfg.day_ewlt_green <= GREEN_W'(6);
      cfg.night_ns_green <= GREEN_W'(6);
      cfg.night_ew_green <= GREEN_W'(5);
      cfg.ped_ns_seconds <= PED_W'(9);
      cfg.ped_ew_seconds <= PED_W'(7);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DAY_NS_GREEN:   cfg.day_ns_green <= cfg_data;
        REG_DAY_EW_GREEN:   cfg.day_ew_green <= cfg_data;
        REG_DAY_NSLT_GREEN: cfg.day_nslt_green <= cfg_data;
        REG_DAY_EWLT_GREEN: cfg.day_ewlt_green <= cfg_data;
        REG_NIGHT_NS_GREEN: cfg.night_ns_green <= cfg_data;
        REG_NIGHT_EW_GREEN: cfg.night_ew_green <= cfg_data;
        REG_PED_NS_SECONDS: cfg.ped_ns_seconds <= cfg_data[PED_W-1:0];
        REG_PED_EW_SECONDS: cfg.ped_ew_seconds <= cfg_data[PED_W-1:0];
        default: ;
      endcase
    end
  end

  tls_seq #(
    .YELLOW_SECONDS    (YELLOW_SECONDS),
    .NIGHT_NSLT_SECONDS(NIGHT_NSLT_SECONDS),
    .NIGHT_EWLT_SECONDS(NIGHT_EWLT_SECONDS)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .tick  (tick),
    .cfg   (cfg),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_valid <= 1'b0;
    end else if (tick_ready) begin
      lamp_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      lamp <= result;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/traffic_light_sequencer_core_checker.sv -----
`timescale 1ns / 1ps

module traffic_light_sequencer_core_checker
  import tls_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 tick_valid,
  input  wire logic                 tick_ready,
  input  wire tick_t                tick,
  input  wire logic                 lamp_valid,
  input  wire logic                 lamp_ready,
  input  wire lamp_t                lamp,
  input  wire logic                 cfg_write,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        mismatches,
  output int                        lamps_owed
);

  localparam logic [SECS_W-1:0] YELLOW_SECS     = SECS_W'(YELLOW_SECONDS_DEF);
  localparam logic [SECS_W-1:0] NIGHT_NSLT_SECS = SECS_W'(NIGHT_NSLT_SECONDS_DEF);
  localparam logic [SECS_W-1:0] NIGHT_EWLT_SECS = SECS_W'(NIGHT_EWLT_SECONDS_DEF);

  cfg_t              timing;
  phase_t            phase;
  logic [SECS_W-1:0] secs_left;
  logic              ped_counting;
  logic              ns_pend;
  logic              ew_pend;
  logic              fl_pend;
  logic              day;
  lamp_t             lamps_due[$];

  function automatic void enter(phase_t p, logic [SECS_W-1:0] secs);
    phase = p;
    secs_left = secs;
    ped_counting = (p == PH_NS_PED) || (p == PH_EW_PED);
  endfunction

  function automatic void start_mode();
    if (!day) begin
      ns_pend = 1'b0;
      ew_pend = 1'b0;
    end
    if (day && ns_pend && timing.ped_ns_seconds != '0) begin
      enter(PH_NS_PED, {1'b0, timing.ped_ns_seconds});
    end else begin
      ns_pend = 1'b0;
      enter(PH_NS_G, day ? timing.day_ns_green : timing.night_ns_green);
    end
  endfunction

  function automatic void start_ew();
    if (day && ew_pend && timing.ped_ew_seconds != '0) begin
      enter(PH_EW_PED, {1'b0, timing.ped_ew_seconds});
    end else begin
      if (day) ew_pend = 1'b0;
      enter(PH_EW_G, day ? timing.day_ew_green : timing.night_ew_green);
    end
  endfunction

  // second flash request ends flashing at the start of a red/off pair
  function automatic void flash_entry();
    if (fl_pend) begin
      fl_pend = 1'b0;
      start_mode();
    end else begin
      enter(PH_FL_RED, 8'd1);
    end
  endfunction

  function automatic void advance(tick_t t);
    case (phase)
      PH_START: begin
        day = t.light_is_day;
        if (fl_pend) begin
          fl_pend = 1'b0;
          flash_entry();
        end else begin
          start_mode();
        end
      end
      PH_NS_PED: begin
        ns_pend = 1'b0;
        enter(PH_NS_G, day ? timing.day_ns_green : timing.night_ns_green);
      end
      PH_NS_G: enter(PH_NS_Y, YELLOW_SECS);
      PH_NS_Y: begin
        if (t.ewlt_car) enter(PH_EWLT_G, day ? timing.day_ewlt_green : NIGHT_EWLT_SECS);
        else start_ew();
      end
      PH_EWLT_G: enter(PH_EWLT_Y, YELLOW_SECS);
      PH_EWLT_Y: start_ew();
      PH_EW_PED: begin
        ew_pend = 1'b0;
        enter(PH_EW_G, day ? timing.day_ew_green : timing.night_ew_green);
      end
      PH_EW_G: enter(PH_EW_Y, YELLOW_SECS);
      PH_EW_Y: begin
        if (t.nslt_car) enter(PH_NSLT_G, day ? timing.day_nslt_green : NIGHT_NSLT_SECS);
        else enter(PH_START, '0);
      end
      PH_NSLT_G: enter(PH_NSLT_Y, YELLOW_SECS);
      PH_FL_RED: enter(PH_FL_OFF, 8'd1);
      PH_FL_OFF: flash_entry();
      default: enter(PH_START, '0);
    endcase
  endfunction

  function automatic lamp_t next_lamps(tick_t t);
    lamp_t r;
    int    n;
    if (t.ns_ped_press) ns_pend = 1'b1;
    if (t.ew_ped_press) ew_pend = 1'b1;
    if (t.flash_press) fl_pend = 1'b1;
    r = '0;
    r.ns_lamp = LAMP_RED;
    r.nslt_lamp = LAMP_RED;
    r.ew_lamp = LAMP_RED;
    r.ewlt_lamp = LAMP_RED;
    for (n = 0; n < 32 && secs_left == '0; n++) advance(t);
    if (secs_left != '0) begin
      case (phase)
        PH_NS_PED, PH_NS_G: r.ns_lamp = LAMP_GREEN;
        PH_NS_Y:            r.ns_lamp = LAMP_YELLOW;
        PH_EWLT_G:          r.ewlt_lamp = LAMP_GREEN;
        PH_EWLT_Y:          r.ewlt_lamp = LAMP_YELLOW;
        PH_EW_PED, PH_EW_G: r.ew_lamp = LAMP_GREEN;
        PH_EW_Y:            r.ew_lamp = LAMP_YELLOW;
        PH_NSLT_G:          r.nslt_lamp = LAMP_GREEN;
        PH_NSLT_Y:          r.nslt_lamp = LAMP_YELLOW;
        PH_FL_OFF: begin
          r.ns_lamp = LAMP_OFF;
          r.nslt_lamp = LAMP_OFF;
          r.ew_lamp = LAMP_OFF;
          r.ewlt_lamp = LAMP_OFF;
        end
        default: ;
      endcase
      if (ped_counting) begin
        r.ped_active = 1'b1;
        r.ped_direction = (phase == PH_EW_PED);
        r.countdown = secs_left[PED_W-1:0] - 7'd1;
      end
      secs_left = secs_left - 8'd1;
    end
    r.day_indicator = day;
    r.beep = r.ped_active;
    return r;
  endfunction

  task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    lamp_t want;
    if (rst) begin
      timing.day_ns_green = 8'd8;
      timing.day_ew_green = 8'd7;
      timing.day_nslt_green = 8'd5;
      timing.day_ewlt_green = 8'd6;
      timing.night_ns_green = 8'd6;
      timing.night_ew_green = 8'd5;
      timing.ped_ns_seconds = 7'd9;
      timing.ped_ew_seconds = 7'd7;
      phase = PH_START;
      secs_left = '0;
      ped_counting = 1'b0;
      ns_pend = 1'b0;
      ew_pend = 1'b0;
      fl_pend = 1'b0;
      day = 1'b0;
      lamps_due.delete();
      mismatches = 0;
    end else begin
      if (lamp_valid && lamp_ready) begin
        if (lamps_due.size() == 0) begin
          mismatches++;
          $display("%0t: lamp item expected none, got %h", $time, lamp);
        end else begin
          want = lamps_due.pop_front();
          check_field("ns_lamp", 8'(want.ns_lamp), 8'(lamp.ns_lamp));
          check_field("nslt_lamp", 8'(want.nslt_lamp), 8'(lamp.nslt_lamp));
          check_field("ew_lamp", 8'(want.ew_lamp), 8'(lamp.ew_lamp));
          check_field("ewlt_lamp", 8'(want.ewlt_lamp), 8'(lamp.ewlt_lamp));
          check_field("day_indicator", 8'(want.day_indicator), 8'(lamp.day_indicator));
          check_field("ped_active", 8'(want.ped_active), 8'(lamp.ped_active));
          check_field("ped_direction", 8'(want.ped_direction), 8'(lamp.ped_direction));
          check_field("countdown", 8'(want.countdown), 8'(lamp.countdown));
          check_field("beep", 8'(want.beep), 8'(lamp.beep));
        end
      end
      if (tick_valid && tick_ready) lamps_due.push_back(next_lamps(tick));
      if (cfg_write) begin
        case (cfg_index)
          REG_DAY_NS_GREEN:   timing.day_ns_green = cfg_data;
          REG_DAY_EW_GREEN:   timing.day_ew_green = cfg_data;
          REG_DAY_NSLT_GREEN: timing.day_nslt_green = cfg_data;
          REG_DAY_EWLT_GREEN: timing.day_ewlt_green = cfg_data;
          REG_NIGHT_NS_GREEN: timing.night_ns_green = cfg_data;
          REG_NIGHT_EW_GREEN: timing.night_ew_green = cfg_data;
          REG_PED_NS_SECONDS: timing.ped_ns_seconds = cfg_data[PED_W-1:0];
          REG_PED_EW_SECONDS: timing.ped_ew_seconds = cfg_data[PED_W-1:0];
          default: ;
        endcase
      end
    end
    lamps_owed = lamps_due.size();
  end

endmodule

// ----- tb/sv/traffic_light_sequencer_core_test.sv -----
`timescale 1ns / 1ps

module traffic_light_sequencer_core_test;
  import tls_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 tick_valid = 1'b0;
  logic                 tick_ready;
  tick_t                tick = '0;
  logic                 lamp_valid;
  logic                 lamp_ready = 1'b1;
  lamp_t                lamp;
  logic                 cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_DAY_NS_GREEN;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   mismatches;
  int                   lamps_owed;
  int                   cycles = 0;
  logic                 tx_idling = 1'b1;
  logic                 rx_idling = 1'b1;

  traffic_light_sequencer_core dut (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_ready (tick_ready),
    .tick       (tick),
    .lamp_valid (lamp_valid),
    .lamp_ready (lamp_ready),
    .lamp       (lamp),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  traffic_light_sequencer_core_checker lamp_check (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_ready (tick_ready),
    .tick       (tick),
    .lamp_valid (lamp_valid),
    .lamp_ready (lamp_ready),
    .lamp       (lamp),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .lamps_owed (lamps_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : lamp_sink
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall == 0 && rx_idling && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 14);
      if (stall != 0) begin
        lamp_ready <= 1'b0;
        stall--;
      end else begin
        lamp_ready <= 1'b1;
      end
    end
  end

  function automatic tick_t mk_tick(logic light, logic nsp, logic ewp, logic ewlt, logic nslt,
                                    logic fl);
    tick_t t;
    t.light_is_day = light;
    t.ns_ped_press = nsp;
    t.ew_ped_press = ewp;
    t.ewlt_car = ewlt;
    t.nslt_car = nslt;
    t.flash_press = fl;
    return t;
  endfunction

  function automatic tick_t rand_tick(int unsigned day_pct);
    return mk_tick($urandom_range(0, 99) < day_pct, $urandom_range(0, 7) == 0,
                   $urandom_range(0, 7) == 0, $urandom_range(0, 1) == 1,
                   $urandom_range(0, 1) == 1, $urandom_range(0, 39) == 0);
  endfunction

  function automatic logic [7:0] rand_green();
    return ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(1, 5));
  endfunction

  function automatic logic [7:0] rand_ped();
    return ($urandom_range(0, 9) == 0) ? 8'd99 : 8'($urandom_range(1, 6));
  endfunction

  task automatic send_tick(tick_t t);
    int unsigned gap;
    gap = (tx_idling && $urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
    if (gap != 0) begin
      @(negedge clk);
      tick_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    tick_valid <= 1'b1;
    tick <= t;
    do @(posedge clk); while (!tick_ready);
  endtask

  // every item yields one lamp item, so nothing owed means idle
  task automatic drain();
    @(negedge clk);
    tick_valid <= 1'b0;
    while (lamps_owed != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_timings(logic [7:0] ns_g, logic [7:0] ew_g, logic [7:0] nslt_g,
                              logic [7:0] ewlt_g, logic [7:0] nt_ns_g, logic [7:0] nt_ew_g,
                              logic [7:0] ped_ns, logic [7:0] ped_ew);
    write_reg(REG_DAY_NS_GREEN, ns_g);
    write_reg(REG_DAY_EW_GREEN, ew_g);
    write_reg(REG_DAY_NSLT_GREEN, nslt_g);
    write_reg(REG_DAY_EWLT_GREEN, ewlt_g);
    write_reg(REG_NIGHT_NS_GREEN, nt_ns_g);
    write_reg(REG_NIGHT_EW_GREEN, nt_ew_g);
    write_reg(REG_PED_NS_SECONDS, ped_ns);
    write_reg(REG_PED_EW_SECONDS, ped_ew);
  endtask

  initial begin : stimulus
    int unsigned rand_items[5];
    int unsigned p;
    int unsigned k;
    int unsigned day_pct;
    rand_items = '{60, 80, 120, 70, 70};
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    for (p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: load_timings(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
        1: load_timings(8'd8, 8'd7, 8'd5, 8'd6, 8'd6, 8'd5, 8'd9, 8'd7);
        2: load_timings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd99, 8'd99);
        default: load_timings(rand_green(), rand_green(), rand_green(), rand_green(),
                              rand_green(), rand_green(), rand_ped(), rand_ped());
      endcase
      tx_idling = (p != 4);
      rx_idling = (p != 4);
      if (p == 0) begin
        // full day cycle with both crossings and both left turns
        for (k = 0; k < 18; k++) send_tick(mk_tick(1'b1, k == 0, k == 0, 1'b1, 1'b1, 1'b0));
        // night start with flash request, then flash exit
        send_tick(mk_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1));
        repeat (3) send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(mk_tick(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1));
        send_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
      end
      day_pct = $urandom_range(10, 90);
      for (k = 0; k < rand_items[p]; k++) send_tick(rand_tick(day_pct));
    end
    drain();
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
src/tls_pkg.sv
src/tls_seq.sv
src/traffic_light_sequencer_core.sv
tb/sv/traffic_light_sequencer_core_checker.sv
tb/sv/traffic_light_sequencer_core_test.sv
